// ===== rtl/deq_pkg.sv =====
package deq_pkg;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_HEAD = 3'd0,
    KIND_PUSH_TAIL = 3'd1,
    KIND_POP_HEAD  = 3'd2,
    KIND_POP_TAIL  = 3'd3,
    KIND_PEEK_HEAD = 3'd4,
    KIND_PEEK_TAIL = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

endpackage

// ===== rtl/deq_if.sv =====
interface deq_req_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::KIND_W-1:0]    kind;
  logic [deq_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::STATUS_W-1:0]  status;
  logic [deq_pkg::DATA_W-1:0]    data;
  logic [deq_pkg::OCC_W-1:0]     occupancy;

  modport source (output valid, output status, output data, output occupancy, input ready);
  modport sink   (input valid, input status, input data, input occupancy, output ready);
endinterface

// ===== rtl/deq_ram.sv =====
module deq_ram #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of DEPTH entries kept in a ring in one synchronous
// RAM. Each request (push or pop at either end, or peek at either end) gives
// exactly one response with status, data and the occupancy after the request.
// Pushes, refused requests and unused kind codes answer from the request, so one
// may be accepted every cycle while no uncollected response holds the output; a
// pop or peek is answered from the registered RAM read in ST_READ. The response
// sits in an output register, so a new request is taken in the same cycle the
// previous response is collected. Only the low DATA_WIDTH bits of a pushed value
// are stored and the occupancy field reports the low five bits of the entry count.
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_req_if.sink   in_req,
  deq_rsp_if.source out_rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  deq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [deq_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [deq_pkg::DATA_W-1:0]       out_data_r, out_data_nxt;
  logic [deq_pkg::OCC_W-1:0]        out_occ_r, out_occ_nxt;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  go_read;
  deq_pkg::status_t      imm_status;
  logic [AW-1:0]         head_inc;
  logic [AW-1:0]         head_dec;
  logic [SW-1:0]         tail_sum;
  logic [SW-1:0]         last_sum;
  logic [AW-1:0]         tail_free;
  logic [AW-1:0]         tail_last;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  assign in_req.ready = (state_r == deq_pkg::ST_IDLE) && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && in_req.ready;

  assign full  = (count_r == DEPTH_C);
  assign empty = (count_r == '0);

  assign head_inc = (head_r == LAST_A) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? LAST_A : head_r - AW'(1);

  // wrap head + count and head + count - 1 back into the ring
  assign tail_sum  = SW'(head_r) + SW'(count_r);
  assign last_sum  = tail_sum - SW'(1);
  assign tail_free = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign tail_last = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);

  assign wr_data = DATA_WIDTH'(in_req.value);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    wr_addr    = head_dec;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    go_read    = 1'b0;
    imm_status = deq_pkg::STATUS_OK;
    case (in_req.kind)
      deq_pkg::KIND_PUSH_HEAD: begin
        if (full) begin
          imm_status = deq_pkg::STATUS_FULL;
        end else begin
          wr_en     = accept;
          wr_addr   = head_dec;
          head_nxt  = accept ? head_dec : head_r;
          count_nxt = accept ? count_r + CW'(1) : count_r;
        end
      end
      deq_pkg::KIND_PUSH_TAIL: begin
        if (full) begin
          imm_status = deq_pkg::STATUS_FULL;
        end else begin
          wr_en     = accept;
          wr_addr   = tail_free;
          count_nxt = accept ? count_r + CW'(1) : count_r;
        end
      end
      deq_pkg::KIND_POP_HEAD: begin
        if (empty) begin
          imm_status = deq_pkg::STATUS_EMPTY;
        end else begin
          go_read   = 1'b1;
          rd_en     = accept;
          rd_addr   = head_r;
          head_nxt  = accept ? head_inc : head_r;
          count_nxt = accept ? count_r - CW'(1) : count_r;
        end
      end
      deq_pkg::KIND_POP_TAIL: begin
        if (empty) begin
          imm_status = deq_pkg::STATUS_EMPTY;
        end else begin
          go_read   = 1'b1;
          rd_en     = accept;
          rd_addr   = tail_last;
          count_nxt = accept ? count_r - CW'(1) : count_r;
        end
      end
      deq_pkg::KIND_PEEK_HEAD: begin
        if (empty) begin
          imm_status = deq_pkg::STATUS_EMPTY;
        end else begin
          go_read = 1'b1;
          rd_en   = accept;
          rd_addr = head_r;
        end
      end
      deq_pkg::KIND_PEEK_TAIL: begin
        if (empty) begin
          imm_status = deq_pkg::STATUS_EMPTY;
        end else begin
          go_read = 1'b1;
          rd_en   = accept;
          rd_addr = tail_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      deq_pkg::ST_IDLE: begin
        if (accept && go_read) begin
          state_nxt = deq_pkg::ST_READ;
        end
      end
      deq_pkg::ST_READ: begin
        state_nxt = deq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = deq_pkg::ST_IDLE;
      end
    endcase
  end

  // load the response from the RAM read or straight from the request
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_occ_nxt    = out_occ_r;
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      deq_pkg::ST_READ: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = deq_pkg::STATUS_OK;
        out_data_nxt   = deq_pkg::DATA_W'(rd_data);
        out_occ_nxt    = deq_pkg::OCC_W'(count_r);
      end
      default: begin
        if (accept && !go_read) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = imm_status;
          out_data_nxt   = '0;
          out_occ_nxt    = deq_pkg::OCC_W'(count_nxt);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.data      = out_data_r;
  assign out_rsp.occupancy = out_occ_r;

  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
